[src/bce_pkg.sv]
// Shared constants, types and helper functions for the binary cross erosion unit.
package bce_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_COLS_RST = CFG_W'(950);
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = CFG_W'(950);

    localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

    // Everything the result stage needs to know about one request.
    typedef struct packed {
        logic             is_c0;
        logic             cb;
        logic             up_ok;
        logic             dn_ok;
        logic             lf_ok;
        logic             rt_ok;
        logic [PIX_W-1:0] dn;
        logic             frame_end;
    } t_op;

    function automatic logic [COLS_W-1:0] eff_cols(input logic [CFG_W-1:0] v);
        int unsigned x;
        x = int'(v);
        if (x < 3) x = 3;
        else if (x > MAX_COLS) x = MAX_COLS;
        return COLS_W'(x);
    endfunction

    function automatic logic [ROWS_W-1:0] eff_rows(input logic [CFG_W-1:0] v);
        int unsigned x;
        x = int'(v);
        if (x < 3) x = 3;
        else if (x > MAX_ROWS) x = MAX_ROWS;
        return ROWS_W'(x);
    endfunction

endpackage

[src/bce_line_bank.sv]
// Generic single-port-write, single-port-read RAM with registered read-first data.
module bce_line_bank #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write at the same address return the old contents.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/binary_cross_erosion_unit.sv]
// Top level of the binary cross erosion unit: 3x3 cross erosion on a raster pixel stream.
//
// The unit takes one request per clock while not stalled and gives results in raster
// order. A pixel of row r, column c releases the eroded pixel of row r-1, column c, so
// output lags input by one line; the first row of a frame gives no result. After the last
// pixel of a frame, one flush request per pixel drains the last row, with frame_end set on
// its final pixel. Each request passes through a read stage, where two line banks of
// MAX_COLS pixels (one per row parity, each one read and one write per cycle) supply the
// right and upper neighbors, and then the result register; the center and left neighbors
// come from a small register window. No clearing pass follows reset. The user must write
// frame size registers only between frames; the unit does not enforce it.
module binary_cross_erosion_unit
    import bce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic                 o_frame_end,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // Configuration
    logic [CFG_W-1:0]  r_cols_cfg, r_rows_cfg;
    logic [COLS_W-1:0] eff_c;
    logic [ROWS_W-1:0] eff_r;

    // Position counters
    logic [ROW_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row;
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [COLS_W-1:0] r_pending, n_pending;

    // Request decode
    logic              in_acc, is_flush, has_res, last_col, last_row;
    logic [COL_W-1:0]  op_col, op_col_p1;
    t_op               op;

    // Read stage and window
    logic              r_s1_valid, s1_adv;
    t_op               r_s1_op;
    logic [PIX_W-1:0]  r_col0 [2];
    logic [PIX_W-1:0]  r_ctr, r_lft;
    logic [PIX_W-1:0]  rd_data [2];
    logic [PIX_W-1:0]  rt, up, ctr, res;
    logic              hit_zero;

    // Result register
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_fe;

    assign eff_c = eff_cols(r_cols_cfg);
    assign eff_r = eff_rows(r_rows_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= FRAME_COLS_RST;
            r_rows_cfg <= FRAME_ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_COLS: r_cols_cfg <= i_cfg_wdata;
                CFG_FRAME_ROWS: r_rows_cfg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_flush   = (t_req'(i_req_type) == REQ_FLUSH);

    assign last_col = (COLS_W'(r_in_col) + COLS_W'(1)) >= eff_c;
    assign last_row = (ROWS_W'(r_in_row) + ROWS_W'(1)) >= eff_r;

    always_comb begin
        op = '0;
        if (is_flush) begin
            op_col       = r_out_col;
            has_res      = (r_pending != '0);
            op.cb        = r_out_row[0];
            op.up_ok     = (r_out_row != '0);
            op.dn_ok     = 1'b0;
            op.rt_ok     = (COLS_W'(r_out_col) + COLS_W'(1)) < eff_c;
            op.dn        = PIX_ZERO;
            op.frame_end = (r_pending == COLS_W'(1));
        end else begin
            op_col       = r_in_col;
            has_res      = (r_in_row != '0);
            // The row above the output row shares a bank with the incoming row.
            op.cb        = ~r_in_row[0];
            op.up_ok     = (r_in_row > ROW_W'(1));
            op.dn_ok     = 1'b1;
            op.rt_ok     = !last_col;
            op.dn        = i_pixel_in;
            op.frame_end = 1'b0;
        end
        op.is_c0  = (op_col == '0);
        op.lf_ok  = (op_col != '0);
        op_col_p1 = op_col + COL_W'(1);
    end

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_pending = r_pending;
        if (in_acc) begin
            if (is_flush) begin
                if (r_pending != '0) begin
                    n_pending = r_pending - COLS_W'(1);
                    n_out_col = r_out_col + COL_W'(1);
                end
            end else begin
                n_pending = '0;
                if (last_col) begin
                    n_in_col = '0;
                    if (last_row) begin
                        n_in_row  = '0;
                        n_pending = eff_c;
                        n_out_row = r_in_row;
                        n_out_col = '0;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                    end
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pending <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_pending <= n_pending;
        end
    end

    // Bank cb is read one column ahead for the right neighbor; the other bank
    // gives the upper neighbor and takes the incoming pixel at the same column.
    for (genvar b = 0; b < 2; b++) begin : g_bank
        bce_line_bank #(
            .DEPTH (MAX_COLS),
            .WIDTH (PIX_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (in_acc && !is_flush && (r_in_row[0] == 1'(b))),
            .i_waddr (r_in_col),
            .i_wdata (i_pixel_in),
            .i_re    (in_acc),
            .i_raddr ((op.cb == 1'(b)) ? op_col_p1 : op_col),
            .o_rdata (rd_data[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_flush && (r_in_col == '0)) begin
            r_col0[r_in_row[0]] <= i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= has_res;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op <= op;
        end
    end

    assign rt  = r_s1_op.cb ? rd_data[1] : rd_data[0];
    assign up  = r_s1_op.cb ? rd_data[0] : rd_data[1];
    assign ctr = r_s1_op.is_c0 ? r_col0[r_s1_op.cb] : r_ctr;

    assign hit_zero = (r_s1_op.up_ok && (up == PIX_ZERO))
                   || (r_s1_op.dn_ok && (r_s1_op.dn == PIX_ZERO))
                   || (r_s1_op.lf_ok && (r_lft == PIX_ZERO))
                   || (r_s1_op.rt_ok && (rt == PIX_ZERO));
    assign res = ((ctr == PIX_FULL) && hit_zero) ? PIX_ZERO : ctr;

    // Requests of one row arrive in column order, so the next center is this
    // request's right neighbor and the next left is this center.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_lft     <= ctr;
            r_ctr     <= rt;
            r_out_pix <= res;
            r_out_fe  <= r_s1_op.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_frame_end = r_out_fe;

endmodule

[bench/tb_binary_cross_erosion_unit.sv]
// Self-checking testbench for the binary cross erosion unit: directed and random frames.
module tb_binary_cross_erosion_unit;
    import bce_pkg::*;

    localparam int ITEM_GOAL     = 700;
    localparam int WIDE_TAIL     = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 160;
    localparam int HOLD_AFTER    = 200;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             frame_last;
    } t_eroded;

    typedef struct {
        t_req             kind;
        logic [PIX_W-1:0] pix;
        bit               typed;
        bit               typed_has;
        t_eroded          typed_res;
    } t_vec;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_req_type;
    logic [PIX_W-1:0]     i_pixel_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_frame_end;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    binary_cross_erosion_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor state: two row banks, frame size and the input and drain positions.
    logic [PIX_W-1:0] line_px [2*MAX_COLS];
    logic [CFG_W-1:0] cfg_cols;
    logic [CFG_W-1:0] cfg_rows;
    int unsigned      at_row;
    int unsigned      at_col;
    int unsigned      drain_row;
    int unsigned      drain_col;
    int unsigned      drain_left;

    t_eroded eroded_q [$];
    t_vec    dir_vecs [25];

    int burst_left;
    int fail_count;
    int results_seen;
    int work_items;
    int frames_done;
    int flushes_sent;
    int resizes;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw,
                                               input int unsigned hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic logic [PIX_W-1:0] stored_px(input int unsigned row,
                                                   input int unsigned col);
        if (col >= MAX_COLS) return PIX_ZERO;
        return line_px[(row & 1) * MAX_COLS + col];
    endfunction

    function automatic logic [PIX_W-1:0] cross_erode(
        input logic [PIX_W-1:0] ctr,
        input bit up_ok, input logic [PIX_W-1:0] up,
        input bit dn_ok, input logic [PIX_W-1:0] dn,
        input bit lf_ok, input logic [PIX_W-1:0] lf,
        input bit rt_ok, input logic [PIX_W-1:0] rt);
        if (ctr != PIX_FULL) return ctr;
        if ((up_ok && up == PIX_ZERO) || (dn_ok && dn == PIX_ZERO) ||
            (lf_ok && lf == PIX_ZERO) || (rt_ok && rt == PIX_ZERO))
            return PIX_ZERO;
        return ctr;
    endfunction

    task automatic predict_erosion(input t_req kind, input logic [PIX_W-1:0] pix,
                                   output bit has, output t_eroded res);
        int unsigned cols;
        int unsigned rows;
        int unsigned r;
        int unsigned c;
        logic [PIX_W-1:0] ctr;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] lf;
        logic [PIX_W-1:0] rt;
        cols = clamp_size(cfg_cols, MAX_COLS);
        rows = clamp_size(cfg_rows, MAX_ROWS);
        has  = 1'b0;
        res  = '0;
        if (kind == REQ_FLUSH) begin
            if (drain_left != 0) begin
                r   = drain_row;
                c   = drain_col;
                ctr = stored_px(r, c);
                up  = stored_px(r + 1, c);
                lf  = (c > 0) ? stored_px(r, c - 1) : PIX_ZERO;
                rt  = stored_px(r, c + 1);
                res.pix = cross_erode(ctr, r > 0, up, 1'b0, PIX_ZERO, c > 0, lf,
                                      c + 1 < cols, rt);
                res.frame_last = (drain_left == 1);
                has = 1'b1;
                drain_left--;
                drain_col = (drain_col + 1) % MAX_COLS;
            end
        end else begin
            r = at_row;
            c = at_col;
            drain_left = 0;
            // A pixel of row r releases row r-1; the bank of row r still holds row r-2.
            if (r >= 1) begin
                ctr = stored_px(r - 1, c);
                up  = stored_px(r, c);
                lf  = (c > 0) ? stored_px(r - 1, c - 1) : PIX_ZERO;
                rt  = stored_px(r - 1, c + 1);
                res.pix = cross_erode(ctr, r > 1, up, 1'b1, pix, c > 0, lf,
                                      c + 1 < cols, rt);
                res.frame_last = 1'b0;
                has = 1'b1;
            end
            if (c < MAX_COLS) line_px[(r & 1) * MAX_COLS + c] = pix;
            if (c + 1 >= cols) begin
                at_col = 0;
                if (r + 1 >= rows) begin
                    at_row     = 0;
                    drain_left = cols;
                    drain_row  = r % MAX_ROWS;
                    drain_col  = 0;
                    frames_done++;
                end else begin
                    at_row = (r + 1) % MAX_ROWS;
                end
            end else begin
                at_col = (c + 1) % MAX_COLS;
            end
        end
    endtask

    // Offer one request, with an occasional gap before a new burst, and wait for it to land.
    task automatic offer_request(input t_req kind, input logic [PIX_W-1:0] pix,
                                 output bit has, output t_eroded res);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                i_req_type <= 1'($urandom);
                i_pixel_in <= PIX_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_erosion(kind, pix, has, res);
    endtask

    task automatic request(input t_req kind, input logic [PIX_W-1:0] pix);
        bit      has;
        t_eroded res;
        offer_request(kind, pix, has, res);
        if (has) eroded_q.push_back(res);
        if (kind == REQ_PIXEL || has) work_items++;
        if (kind == REQ_FLUSH) flushes_sent++;
    endtask

    // Frame size changes only once every result is out and the pipeline has emptied.
    task automatic resize_frame(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (eroded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FRAME_COLS;
        i_cfg_wdata <= cols;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_FRAME_ROWS;
        i_cfg_wdata <= rows;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_cols = cols;
        cfg_rows = rows;
        resizes++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int zero_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct) return PIX_ZERO;
        if (roll < 92) return PIX_FULL;
        return PIX_W'($urandom);
    endfunction

    // Finishes the frame in progress, or sends a whole one from its first pixel.
    task automatic run_frame(input int zero_pct);
        do begin
            if ($urandom_range(0, 39) == 0) request(REQ_FLUSH, PIX_W'($urandom));
            request(REQ_PIXEL, pick_pixel(zero_pct));
        end while (at_row != 0 || at_col != 0);
    endtask

    // Drains the last row in full or part, with spare flushes at times; a pixel drops the rest.
    task automatic drain_rows(input bit all_of_it);
        int n;
        n = all_of_it ? drain_left : $urandom_range(0, drain_left);
        repeat (n) request(REQ_FLUSH, PIX_W'($urandom));
        if (drain_left == 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) request(REQ_FLUSH, PIX_W'($urandom));
    endtask

    always @(posedge i_clk) begin
        t_eroded want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_seen++;
            if (eroded_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual pixel_out %0d frame_end %0b",
                         $time, o_pixel_out, o_frame_end);
            end else begin
                want = eroded_q.pop_front();
                if (o_pixel_out !== want.pix) begin
                    fail_count++;
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, want.pix, o_pixel_out);
                end
                if (o_frame_end !== want.frame_last) begin
                    fail_count++;
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, want.frame_last, o_frame_end);
                end
            end
        end
    end

    // Output side: stall bursts at changing rates, plus one long hold-off that backs up the input.
    initial begin
        int span;
        int stall_pct;
        bit held;
        held = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            stall_pct = 25 * $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span) begin
                @(negedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
        $display("binary_cross_erosion_unit: mismatch");
        $finish;
    end

    initial begin
        bit      has;
        t_eroded res;
        bit      resize;
        int      roll;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_PIXEL;
        i_pixel_in  = PIX_ZERO;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_FRAME_COLS;
        i_cfg_wdata = '0;
        foreach (line_px[i]) line_px[i] = PIX_ZERO;
        cfg_cols     = FRAME_COLS_RST;
        cfg_rows     = FRAME_ROWS_RST;
        at_row       = 0;
        at_col       = 0;
        drain_row    = 0;
        drain_col    = 0;
        drain_left   = 0;
        burst_left   = 0;
        fail_count   = 0;
        results_seen = 0;
        work_items   = 0;
        frames_done  = 0;
        flushes_sent = 0;
        resizes      = 0;

        // First frame: a zero in the middle of an all-ones 3x3 image.
        // Second frame: mixed values, a partial drain and a pixel that drops the rest.
        dir_vecs = '{
            '{REQ_FLUSH, 8'hA5, 1'b1, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0}},
            '{REQ_PIXEL, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0}},
            '{REQ_FLUSH, 8'h5A, 1'b1, 1'b1, '{8'hFF, 1'b0}},
            '{REQ_FLUSH, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0}},
            '{REQ_FLUSH, 8'h00, 1'b1, 1'b1, '{8'hFF, 1'b1}},
            '{REQ_FLUSH, 8'hC3, 1'b1, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'h01, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFE, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'h80, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'h7F, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_FLUSH, 8'h3C, 1'b0, 1'b0, '{8'h00, 1'b0}},
            '{REQ_PIXEL, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0}}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Both sizes below the floor, so the frame is 3x3.
        resize_frame(CFG_W'(0), CFG_W'(1));
        foreach (dir_vecs[i]) begin
            offer_request(dir_vecs[i].kind, dir_vecs[i].pix, has, res);
            if (dir_vecs[i].typed) begin
                has = dir_vecs[i].typed_has;
                res = dir_vecs[i].typed_res;
            end
            if (has) eroded_q.push_back(res);
        end

        work_items = 0;
        while (work_items < ITEM_GOAL) begin
            run_frame(5 + 15 * $urandom_range(0, 3));
            resize = ($urandom_range(0, 3) == 0);
            drain_rows(resize || $urandom_range(0, 2) != 0);
            if (resize) begin
                roll = $urandom_range(0, 19);
                resize_frame((roll < 3) ? CFG_W'($urandom_range(0, 2)) :
                             (roll < 6) ? CFG_W'($urandom_range(13, 40)) :
                                          CFG_W'($urandom_range(3, 12)),
                             ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2)) :
                                                           CFG_W'($urandom_range(3, 7)));
            end
        end

        // The column register above the maximum: a full-width first row and part of the
        // second, so the row wraps at MAX_COLS and the second row gives results.
        if (drain_left != 0) drain_rows(1'b1);
        resize_frame('1, '0);
        repeat (MAX_COLS + WIDE_TAIL) request(REQ_PIXEL, pick_pixel(20));

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (eroded_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d frames over %0d frame sizes up to %0d columns, %0d results checked",
                 frames_done, resizes, MAX_COLS, results_seen);
        $display("%0d flush requests, random stalls on both sides, one %0d-cycle output hold-off",
                 flushes_sent, HOLD_CYCLES);
        if (fail_count == 0)
            $display("binary_cross_erosion_unit: match");
        else
            $display("binary_cross_erosion_unit: mismatch");
        $finish;
    end

endmodule

[binary_cross_erosion_unit.f]
src/bce_pkg.sv
src/bce_line_bank.sv
src/binary_cross_erosion_unit.sv
bench/tb_binary_cross_erosion_unit.sv
